### rtl/gpio_register_block_defines.svh
// Assertion macros used by the GPIO register block checker
`ifndef GPIO_REGISTER_BLOCK_DEFINES_SVH
`define GPIO_REGISTER_BLOCK_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define GRB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define GRB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gpio_rb_pkg.sv
// Types, register codes and mask helpers for the GPIO register block
`timescale 1ns / 1ps

package gpio_rb_pkg;

    localparam int DATA_W        = 32;
    localparam int PIN_W         = 54;
    localparam int FSEL_WORDS    = 6;
    localparam int PINS_PER_WORD = 10;
    localparam int FIELD_W       = 3;
    localparam int FSEL_W        = PINS_PER_WORD * FIELD_W;
    localparam int FSEL_IDX_W    = $clog2(FSEL_WORDS);
    localparam int HALF_SPLIT    = 32;
    localparam int PULL_W        = 2;
    localparam int SEL_W         = 4;
    localparam int PIN_COUNT_DEF = 54;

    // Stream packing widths
    localparam int S_TDATA_W = ((DATA_W + PIN_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1 + SEL_W;
    localparam int M_TDATA_W = ((DATA_W + 2 * PIN_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [FIELD_W-1:0] FSEL_OUTPUT = 3'd1;

    localparam logic [SEL_W-1:0] REG_FSEL0  = 4'd0;
    localparam logic [SEL_W-1:0] REG_FSEL1  = 4'd1;
    localparam logic [SEL_W-1:0] REG_FSEL2  = 4'd2;
    localparam logic [SEL_W-1:0] REG_FSEL3  = 4'd3;
    localparam logic [SEL_W-1:0] REG_FSEL4  = 4'd4;
    localparam logic [SEL_W-1:0] REG_FSEL5  = 4'd5;
    localparam logic [SEL_W-1:0] REG_SET0   = 4'd6;
    localparam logic [SEL_W-1:0] REG_SET1   = 4'd7;
    localparam logic [SEL_W-1:0] REG_CLR0   = 4'd8;
    localparam logic [SEL_W-1:0] REG_CLR1   = 4'd9;
    localparam logic [SEL_W-1:0] REG_LEVEL0 = 4'd10;
    localparam logic [SEL_W-1:0] REG_LEVEL1 = 4'd11;
    localparam logic [SEL_W-1:0] REG_PULL   = 4'd12;

    typedef struct packed {
        logic               func;
        logic [SEL_W-1:0]   reg_sel;
        logic [DATA_W-1:0]  write_data;
        logic [PIN_W-1:0]   pin_levels;
    } gpio_rb_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [PIN_W-1:0]   out_levels;
        logic [PIN_W-1:0]   out_enable;
        logic               bad_address;
    } gpio_rb_rsp_t;

    // One bit per implemented pin
    function automatic logic [PIN_W-1:0] pin_mask(input int count);
        logic [PIN_W-1:0] m;
        m = '0;
        for (int p = 0; p < PIN_W; p++)
        begin
            if (p < count)
            begin
                m[p] = 1'b1;
            end
        end
        return m;
    endfunction

    // Function-select field bits of one word that belong to implemented pins
    function automatic logic [FSEL_W-1:0] fsel_mask(input int word, input int count);
        logic [FSEL_W-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_WORD; k++)
        begin
            if (word * PINS_PER_WORD + k < count)
            begin
                m[k*FIELD_W +: FIELD_W] = '1;
            end
        end
        return m;
    endfunction

endpackage

### rtl/gpio_register_block.sv
// GPIO register block top level: input register, register file, result register
//
//   channel   dir  tuser              tdata
//   s_axis    in   func, reg_sel      write_data, pin_levels
//   m_axis    out  bad_address        read_data, out_levels, out_enable
//
// One bus access per cycle sustained while m_axis is ready; each beat passes through
// the input register, then decode and state update into the result register.
// The state update happens as the access moves into the result register, so
// accesses take effect strictly in order.
// Reset clears function fields, output latch and pull control; no clearing pass.
// A stall on m_axis holds the result and backs up into the input register.
`timescale 1ns / 1ps

module gpio_register_block #(
    parameter int PIN_COUNT = gpio_rb_pkg::PIN_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // write_data, pin_levels, zero pad
    input  logic [gpio_rb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func, reg_sel
    input  logic [gpio_rb_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_data, out_levels, out_enable, zero pad
    output logic [gpio_rb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // bad_address
    output logic [gpio_rb_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import gpio_rb_pkg::*;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    gpio_rb_req_t  s1_req_reg;
    gpio_rb_req_t  s_req;
    logic          out_valid_reg;
    logic          out_valid_next;
    gpio_rb_rsp_t  out_rsp_reg;
    gpio_rb_rsp_t  rsp;
    logic          out_free;
    logic          s1_adv;
    logic          s_acc;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        s_req.func       = s_axis_tuser[0];
        s_req.reg_sel    = s_axis_tuser[SEL_W:1];
        s_req.write_data = s_axis_tdata[DATA_W-1:0];
        s_req.pin_levels = s_axis_tdata[DATA_W+PIN_W-1:DATA_W];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_req_reg <= s_req;
        end
        if (s1_adv)
        begin
            out_rsp_reg <= rsp;
        end
    end

    gpio_rb_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (s1_req_reg),
        .commit (s1_adv),
        .rsp    (rsp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-DATA_W-2*PIN_W){1'b0}},
                            out_rsp_reg.out_enable,
                            out_rsp_reg.out_levels,
                            out_rsp_reg.read_data};
    assign m_axis_tuser  = out_rsp_reg.bad_address;

endmodule

### rtl/gpio_rb_regs.sv
// GPIO register file: access decode, state registers and result forming
`timescale 1ns / 1ps

module gpio_rb_regs #(
    parameter int PIN_COUNT = gpio_rb_pkg::PIN_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gpio_rb_pkg::gpio_rb_req_t req,
    input  logic                      commit,
    output gpio_rb_pkg::gpio_rb_rsp_t rsp
);
    import gpio_rb_pkg::*;

    localparam logic [PIN_W-1:0] PMASK = pin_mask(PIN_COUNT);

    logic [FSEL_W-1:0]     fsel_reg  [FSEL_WORDS];
    logic [FSEL_W-1:0]     fsel_next [FSEL_WORDS];
    logic [PIN_W-1:0]      latch_reg;
    logic [PIN_W-1:0]      latch_next;
    logic [PULL_W-1:0]     pull_reg;
    logic [PULL_W-1:0]     pull_next;
    logic [FSEL_IDX_W-1:0] sel_idx;
    logic [PIN_W-1:0]      levels;
    logic [PIN_W-1:0]      en;
    logic [DATA_W-1:0]     rd;
    logic                  bad;
    logic                  wr;

    assign sel_idx = req.reg_sel[FSEL_IDX_W-1:0];
    assign levels  = req.pin_levels & PMASK;
    assign wr      = (req.func == FUNC_WRITE);

    always_comb
    begin
        fsel_next  = fsel_reg;
        latch_next = latch_reg;
        pull_next  = pull_reg;
        rd         = '0;
        bad        = 1'b0;
        case (req.reg_sel)
            REG_FSEL0, REG_FSEL1, REG_FSEL2, REG_FSEL3, REG_FSEL4, REG_FSEL5:
            begin
                if (wr)
                begin
                    fsel_next[sel_idx] = req.write_data[FSEL_W-1:0]
                                       & fsel_mask(int'(sel_idx), PIN_COUNT);
                end
                else
                begin
                    rd = {{(DATA_W-FSEL_W){1'b0}}, fsel_reg[sel_idx]};
                end
            end
            REG_SET0:
            begin
                if (wr)
                begin
                    latch_next = latch_reg | (PIN_W'(req.write_data) & PMASK);
                end
            end
            REG_SET1:
            begin
                if (wr)
                begin
                    latch_next = latch_reg
                               | ({req.write_data[PIN_W-HALF_SPLIT-1:0],
                                   {HALF_SPLIT{1'b0}}} & PMASK);
                end
            end
            REG_CLR0:
            begin
                if (wr)
                begin
                    latch_next = latch_reg & ~(PIN_W'(req.write_data) & PMASK);
                end
            end
            REG_CLR1:
            begin
                if (wr)
                begin
                    latch_next = latch_reg
                               & ~({req.write_data[PIN_W-HALF_SPLIT-1:0],
                                    {HALF_SPLIT{1'b0}}} & PMASK);
                end
            end
            REG_LEVEL0:
            begin
                rd = levels[HALF_SPLIT-1:0];
            end
            REG_LEVEL1:
            begin
                rd = DATA_W'(levels[PIN_W-1:HALF_SPLIT]);
            end
            REG_PULL:
            begin
                if (wr)
                begin
                    pull_next = req.write_data[PULL_W-1:0];
                end
                else
                begin
                    rd = {{(DATA_W-PULL_W){1'b0}}, pull_reg};
                end
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
    end

    // Output enable follows the function fields after this access
    for (genvar p = 0; p < PIN_W; p++)
    begin : g_en
        assign en[p] = (fsel_next[p / PINS_PER_WORD][(p % PINS_PER_WORD)*FIELD_W +: FIELD_W]
                        == FSEL_OUTPUT);
    end

    always_comb
    begin
        rsp.read_data   = wr ? '0 : rd;
        rsp.out_levels  = latch_next;
        rsp.out_enable  = en;
        rsp.bad_address = bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < FSEL_WORDS; w++)
            begin
                fsel_reg[w] <= '0;
            end
            latch_reg <= '0;
            pull_reg  <= '0;
        end
        else if (commit)
        begin
            fsel_reg  <= fsel_next;
            latch_reg <= latch_next;
            pull_reg  <= pull_next;
        end
    end

endmodule

### rtl/gpio_rb_checker.sv
// Port-level checks for the GPIO register block, bound to the top level
`timescale 1ns / 1ps
`include "gpio_register_block_defines.svh"

module gpio_rb_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [gpio_rb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [gpio_rb_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import gpio_rb_pkg::*;

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       s_acc;
    logic       m_acc;
    logic       bad_flag;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign m_acc    = m_axis_tvalid && m_axis_tready;
    assign bad_flag = m_axis_tuser[0];

    // Count beats taken in but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (s_acc && !m_acc)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (m_acc && !s_acc)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `GRB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `GRB_ASSERT_NOW(a_out_has_src, m_axis_tvalid, inflight_reg != 2'd0, "result without an access")
    `GRB_ASSERT_NOW(a_depth, s_acc || m_acc || m_axis_tvalid, inflight_reg <= 2'd2, "more than two accesses in flight")
    `GRB_ASSERT_NOW(a_bad_reads_zero, m_axis_tvalid && bad_flag, m_axis_tdata[DATA_W-1:0] == '0, "unknown register returned data")

endmodule

bind gpio_register_block gpio_rb_checker u_gpio_rb_checker (.*);
